[rtl/lru_pkg.sv]
package lru_pkg;

	localparam int FRAMES_DEF    = 64;
	localparam int PAGE_BITS_DEF = 16;
	localparam int CFG_W         = 7;
	localparam int CNT_W         = 32;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Signals that ripple from one stack cell to the next one down.
	typedef struct packed {
		logic valid;   // the cell above holds a resident page
		logic hit;     // some cell above (or this one) matched the request
	} link_t;

endpackage

[rtl/lru_cell.sv]
module lru_cell #(
	parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
	parameter int IDX       = 0,
	parameter int EFF_W     = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic                 miss,
	input  logic [EFF_W-1:0]     eff_size,
	input  logic [PAGE_BITS-1:0] req_page,
	input  logic [PAGE_BITS-1:0] page_in,
	input  lru_pkg::link_t       link_in,
	output logic [PAGE_BITS-1:0] page_out,
	output lru_pkg::link_t       link_out
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic                 match;
	logic                 shift;
	logic                 keep_ok;

	assign match   = valid_q && (page_q == req_page);
	// Every cell down to the matching one moves; on a miss the whole row moves.
	assign shift   = load && !link_in.hit;
	assign keep_ok = EFF_W'(IDX) < eff_size;

	always_ff @(posedge clk) begin
		if (shift) begin
			page_q <= page_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && miss) begin
			valid_q <= link_in.valid && keep_ok;
		end
	end

	assign page_out       = page_q;
	assign link_out.valid = valid_q;
	assign link_out.hit   = link_in.hit || match;

endmodule

[rtl/lru_page_replacement_core.sv]
// Channel  | Direction | Handshake          | Payload
// s_*      | in        | s_tvalid/s_tready  | page number
// m_*      | out       | m_tvalid/m_tready  | fault, request total, fault total
// cfg_*    | in        | cfg_valid/cfg_ready| cache_size
//
// One request per cycle: the compare-and-shift row of cells finds the hit and
// reorders the stack in the cycle of the transfer, and the result is loaded into
// the output register and shown in the cycle after. The input is stalled only
// while that result waits on m_tready. Reset empties the stack, clears both
// totals and sets cache_size to 64; configuration is always accepted.
module lru_page_replacement_core #(
	parameter int FRAMES    = lru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [((PAGE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // [PAGE_BITS-1:0] page
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [((1 + 2 * lru_pkg::CNT_W + 7) / 8) * 8 - 1:0] m_tdata,
	                                             // [0] fault, [32:1] request_total,
	                                             // [64:33] fault_total
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lru_pkg::CFG_W-1:0] cfg_data  // cache_size
);

	localparam int RES_W = 1 + 2 * lru_pkg::CNT_W;
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;
	localparam int EFF_W = $clog2(FRAMES + 1);

	logic [lru_pkg::CFG_W-1:0] cache_size_q;
	logic [EFF_W-1:0]          eff_size;
	logic [31:0]               cfg_ext;
	logic [lru_pkg::CNT_W-1:0] req_q;
	logic [lru_pkg::CNT_W-1:0] flt_q;
	logic                      out_valid_q;
	logic                      out_fault_q;
	logic [lru_pkg::CNT_W-1:0] out_req_q;
	logic [lru_pkg::CNT_W-1:0] out_flt_q;
	logic                      accept;
	logic                      miss;
	logic [PAGE_BITS-1:0]      req_page;
	logic [PAGE_BITS-1:0]      page_chain [0:FRAMES];
	lru_pkg::link_t            link_chain [0:FRAMES];
	logic [FRAMES-1:0]         valid_vec;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign req_page  = s_tdata[PAGE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_size_q <= lru_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cache_size_q <= cfg_data;
		end
	end

	// Zero acts as one frame, anything beyond the built row as the whole row.
	always_comb begin
		cfg_ext = 32'(cache_size_q);
		if (cfg_ext == 32'd0) begin
			eff_size = EFF_W'(1);
		end else if (cfg_ext > 32'(FRAMES)) begin
			eff_size = EFF_W'(FRAMES);
		end else begin
			eff_size = EFF_W'(cfg_ext);
		end
	end

	assign page_chain[0]       = req_page;
	assign link_chain[0].valid = 1'b1;
	assign link_chain[0].hit   = 1'b0;
	assign miss                = !link_chain[FRAMES].hit;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lru_cell #(
			.PAGE_BITS(PAGE_BITS),
			.IDX      (i),
			.EFF_W    (EFF_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (accept),
			.miss    (miss),
			.eff_size(eff_size),
			.req_page(req_page),
			.page_in (page_chain[i]),
			.link_in (link_chain[i]),
			.page_out(page_chain[i+1]),
			.link_out(link_chain[i+1])
		);
		assign valid_vec[i] = link_chain[i+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q       <= '0;
			flt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				req_q <= req_q + 1'b1;
				if (miss) begin
					flt_q <= flt_q + 1'b1;
				end
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_fault_q <= miss;
			out_req_q   <= req_q + 1'b1;
			out_flt_q   <= miss ? flt_q + 1'b1 : flt_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, out_flt_q, out_req_q, out_fault_q};

	// Resident pages always fill the top of the stack without gaps.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("resident slots do not form a prefix");

	// A miss never leaves more resident pages than the effective size.
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept && miss |=> $countones(valid_vec) <= 32'($past(eff_size)))
		else $error("stack holds more pages than the cache size");

	// A shown result carries the totals that the counters now hold.
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_req_q == req_q) && (out_flt_q == flt_q))
		else $error("result totals disagree with counters");

	// A hit leaves the fault total where it was.
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !miss |=> flt_q == $past(flt_q))
		else $error("fault total moved on a hit");

	// After any request, hit or miss, the requested page is resident at the top.
	a_top_page: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_vec[0] && (page_chain[1] == $past(req_page)))
		else $error("requested page not at the top of the stack");

endmodule
